### rtl/bcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcb_pkg
// shared types, constants and helpers of the bidirectional csr builder
// ----------------------------------------------------------------------------
package bcb_pkg;

    localparam int DEF_NODE_COUNT    = 4096;
    localparam int DEF_EDGE_CAPACITY = 65536;

    localparam int MODE_W = 2;
    localparam int NODE_W = 32;
    localparam int IDX_W  = 13;
    localparam int SLOT_W = 17;

    localparam int SLOT_MAX = 131071;

    typedef enum logic [MODE_W-1:0] {
        MODE_COUNT = 2'd0,
        MODE_SCAN  = 2'd1,
        MODE_PLACE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic exec;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic needs_out;
        logic out_stall;
    } dp_status_t;

    // saturating add of two slot values
    function automatic logic [SLOT_W-1:0] sat_add(
        input logic [SLOT_W-1:0] a,
        input logic [SLOT_W-1:0] b,
        input logic [SLOT_W-1:0] lim
    );
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, lim}) ? lim : s[SLOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/bcb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcb_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module bcb_ram #(
    parameter int WIDTH  = 17,
    parameter int DEPTH  = 4097,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/bcb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcb_ctrl
// sequencer: clearing pass, word accept, table read, update
// ----------------------------------------------------------------------------
module bcb_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bcb_pkg::dp_status_t status,
    output bcb_pkg::ctrl_cmd_t      cmd
);
    import bcb_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   exec_go;

    assign exec_go = (state_reg == ST_EXEC) && !(status.needs_out && status.out_stall);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (status.clear_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  if (exec_go) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cmd.load  = (state_reg == ST_IDLE) && s_valid;
    assign cmd.clear = (state_reg == ST_CLEAR);
    assign cmd.exec  = exec_go;

endmodule
`default_nettype wire

### rtl/bcb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcb_datapath
// word register, degree/cursor tables, running sums and result register
// ----------------------------------------------------------------------------
module bcb_datapath #(
    parameter int NODE_COUNT    = bcb_pkg::DEF_NODE_COUNT,
    parameter int EDGE_CAPACITY = bcb_pkg::DEF_EDGE_CAPACITY
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bcb_pkg::ctrl_cmd_t           cmd,
    output bcb_pkg::dp_status_t               status,
    input  wire logic [bcb_pkg::MODE_W-1:0]   s_mode,
    input  wire logic [bcb_pkg::NODE_W-1:0]   s_src_node,
    input  wire logic [bcb_pkg::NODE_W-1:0]   s_dst_node,
    input  wire logic [bcb_pkg::NODE_W-1:0]   s_edge_weight,
    input  wire logic [bcb_pkg::IDX_W-1:0]    s_scan_index,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [bcb_pkg::SLOT_W-1:0]   m_fwd_slot,
    output logic      [bcb_pkg::SLOT_W-1:0]   m_bwd_slot,
    output logic      [bcb_pkg::NODE_W-1:0]   m_fwd_entry_node,
    output logic      [bcb_pkg::NODE_W-1:0]   m_bwd_entry_node,
    output logic      [bcb_pkg::NODE_W-1:0]   m_entry_weight,
    output logic                              m_out_of_range
);
    import bcb_pkg::*;

    localparam int DEPTH     = NODE_COUNT + 1;
    localparam int AW        = $clog2(DEPTH);
    localparam int SAT_LIM_I = (EDGE_CAPACITY < SLOT_MAX) ? EDGE_CAPACITY : SLOT_MAX;
    localparam logic [SLOT_W-1:0] SAT_LIM   = SLOT_W'(SAT_LIM_I);
    localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1);
    localparam logic [NODE_W-1:0] NODES     = NODE_W'(NODE_COUNT);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(NODE_COUNT);

    // held word
    mode_t             mode_reg;
    logic [NODE_W-1:0] src_reg, dst_reg, wgt_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [AW-1:0]     clr_cnt_reg;
    logic [SLOT_W-1:0] fwd_run_reg, bwd_run_reg;
    logic              m_valid_reg;

    logic [NODE_W-1:0] idx_ext;
    logic              src_ok, dst_ok, idx_ok, is_scan, is_edge;
    logic [AW-1:0]     fwd_raddr, bwd_raddr, fwd_waddr, bwd_waddr;
    logic [SLOT_W-1:0] fwd_rdata, bwd_rdata, fwd_wdata, bwd_wdata;
    logic              fwd_we, bwd_we, fwd_en, bwd_en;
    logic [SLOT_W-1:0] run_f, run_b;

    assign idx_ext = NODE_W'(idx_reg);
    assign src_ok  = src_reg < NODES;
    assign dst_ok  = dst_reg < NODES;
    assign idx_ok  = idx_ext <= NODES;
    assign is_scan = (mode_reg == MODE_SCAN);
    assign is_edge = (mode_reg == MODE_COUNT) || (mode_reg == MODE_PLACE);

    assign fwd_raddr = is_scan ? idx_ext[AW-1:0] : dst_reg[AW-1:0];
    assign bwd_raddr = is_scan ? idx_ext[AW-1:0] : src_reg[AW-1:0];

    // scan index zero restarts the running sums
    assign run_f = (idx_reg == '0) ? '0 : fwd_run_reg;
    assign run_b = (idx_reg == '0) ? '0 : bwd_run_reg;

    assign fwd_en = (is_edge && dst_ok) || (is_scan && idx_ok);
    assign bwd_en = (is_edge && src_ok) || (is_scan && idx_ok);

    assign fwd_we    = cmd.clear || (cmd.exec && fwd_en);
    assign bwd_we    = cmd.clear || (cmd.exec && bwd_en);
    assign fwd_waddr = cmd.clear ? clr_cnt_reg : fwd_raddr;
    assign bwd_waddr = cmd.clear ? clr_cnt_reg : bwd_raddr;
    assign fwd_wdata = cmd.clear ? '0 :
                       (is_scan ? run_f : sat_add(fwd_rdata, SLOT_ONE, SAT_LIM));
    assign bwd_wdata = cmd.clear ? '0 :
                       (is_scan ? run_b : sat_add(bwd_rdata, SLOT_ONE, SAT_LIM));

    bcb_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH), .ADDR_W(AW)) u_fwd_ram (
        .aclk  (aclk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    bcb_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH), .ADDR_W(AW)) u_bwd_ram (
        .aclk  (aclk),
        .we    (bwd_we),
        .waddr (bwd_waddr),
        .wdata (bwd_wdata),
        .raddr (bwd_raddr),
        .rdata (bwd_rdata)
    );

    // word register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= mode_t'(s_mode);
            src_reg  <= s_src_node;
            dst_reg  <= s_dst_node;
            wgt_reg  <= s_edge_weight;
            idx_reg  <= s_scan_index;
        end
    end

    // clear counter and running sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            fwd_run_reg <= '0;
            bwd_run_reg <= '0;
        end else begin
            if (cmd.clear && clr_cnt_reg != LAST_ADDR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.exec && is_scan && idx_ok) begin
                fwd_run_reg <= sat_add(run_f, fwd_rdata, SAT_LIM);
                bwd_run_reg <= sat_add(run_b, bwd_rdata, SAT_LIM);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec && (is_scan || mode_reg == MODE_PLACE)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && is_scan) begin
            m_fwd_slot       <= idx_ok ? run_f : '0;
            m_bwd_slot       <= idx_ok ? run_b : '0;
            m_fwd_entry_node <= '0;
            m_bwd_entry_node <= '0;
            m_entry_weight   <= '0;
            m_out_of_range   <= !idx_ok;
        end else if (cmd.exec && mode_reg == MODE_PLACE) begin
            m_fwd_slot       <= dst_ok ? fwd_rdata : '0;
            m_bwd_slot       <= src_ok ? bwd_rdata : '0;
            m_fwd_entry_node <= dst_ok ? src_reg : '0;
            m_bwd_entry_node <= src_ok ? dst_reg : '0;
            m_entry_weight   <= wgt_reg;
            m_out_of_range   <= !(src_ok && dst_ok);
        end
    end

    assign m_valid           = m_valid_reg;
    assign status.clear_last = (clr_cnt_reg == LAST_ADDR);
    assign status.needs_out  = is_scan || (mode_reg == MODE_PLACE);
    assign status.out_stall  = m_valid_reg && !m_ready;

endmodule
`default_nettype wire

### rtl/bidirectional_csr_builder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bidirectional_csr_builder_top
// forward and backward csr index builder from weighted edge words
// ----------------------------------------------------------------------------
// Each input word passes through three steps: accept, table read, table update
// with result capture; the steps follow from the registered read of the two
// table memories and their write-back. A finished result sits in an output
// register, so the next word is accepted while it waits; only an update that
// produces a result holds while that register is still full. After reset the
// block clears all NODE_COUNT+1 entries of both tables in one pass, with
// s_ready low throughout. Mode 0 counts an edge into the destination (forward)
// and source (backward) degree tables and returns nothing; mode 1 turns the
// degree of node s_scan_index into its exclusive prefix offset and returns it
// (index zero restarts the sums); mode 2 places an edge, returning both cursor
// positions and the entry to store there. Mode 3 is ignored.
// ----------------------------------------------------------------------------
module bidirectional_csr_builder_top #(
    parameter int NODE_COUNT    = bcb_pkg::DEF_NODE_COUNT,
    parameter int EDGE_CAPACITY = bcb_pkg::DEF_EDGE_CAPACITY
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input words
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [bcb_pkg::MODE_W-1:0] s_mode,
    input  wire logic [bcb_pkg::NODE_W-1:0] s_src_node,
    input  wire logic [bcb_pkg::NODE_W-1:0] s_dst_node,
    input  wire logic [bcb_pkg::NODE_W-1:0] s_edge_weight,
    input  wire logic [bcb_pkg::IDX_W-1:0]  s_scan_index,
    // result words
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [bcb_pkg::SLOT_W-1:0] m_fwd_slot,
    output logic      [bcb_pkg::SLOT_W-1:0] m_bwd_slot,
    output logic      [bcb_pkg::NODE_W-1:0] m_fwd_entry_node,
    output logic      [bcb_pkg::NODE_W-1:0] m_bwd_entry_node,
    output logic      [bcb_pkg::NODE_W-1:0] m_entry_weight,
    output logic                            m_out_of_range
);
    import bcb_pkg::*;

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: clearing pass, then accept / read / update per word
    bcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // tables, running sums and result register
    bcb_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .EDGE_CAPACITY (EDGE_CAPACITY)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_mode           (s_mode),
        .s_src_node       (s_src_node),
        .s_dst_node       (s_dst_node),
        .s_edge_weight    (s_edge_weight),
        .s_scan_index     (s_scan_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_fwd_slot       (m_fwd_slot),
        .m_bwd_slot       (m_bwd_slot),
        .m_fwd_entry_node (m_fwd_entry_node),
        .m_bwd_entry_node (m_bwd_entry_node),
        .m_entry_weight   (m_entry_weight),
        .m_out_of_range   (m_out_of_range)
    );

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bidirectional csr builder
// ----------------------------------------------------------------------------
// A queue of input words is filled up front: a short directed list, then
// rounds of count / scan / place sequences over a small node pool, with noise
// in between. A clocked driver feeds the words with random gaps. A predictor
// keeps its own degree tables and running sums and files the expected result
// word of every accepted word with a result. A clocked monitor stalls at random
// and compares each result word, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
    import bcb_pkg::*;

    localparam int NODES   = DEF_NODE_COUNT;
    localparam int CAP     = DEF_EDGE_CAPACITY;
    // counts, sums and cursors stop at the smaller of capacity and slot max
    localparam int SAT_LIM = (CAP < SLOT_MAX) ? CAP : SLOT_MAX;
    localparam int N_RANDOM = 1600;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        mode_t             mode;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [NODE_W-1:0] wgt;
        logic [IDX_W-1:0]  idx;
    } edge_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0] fwd_slot;
        logic [SLOT_W-1:0] bwd_slot;
        logic [NODE_W-1:0] fwd_node;
        logic [NODE_W-1:0] bwd_node;
        logic [NODE_W-1:0] weight;
        logic              oor;
    } slot_word_t;

    // clock, reset and block inputs, all known from time zero
    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic [MODE_W-1:0] s_mode        = '0;
    logic [NODE_W-1:0] s_src_node    = '0;
    logic [NODE_W-1:0] s_dst_node    = '0;
    logic [NODE_W-1:0] s_edge_weight = '0;
    logic [IDX_W-1:0]  s_scan_index  = '0;
    logic              m_ready       = 1'b0;

    logic              s_ready;
    logic              m_valid;
    logic [SLOT_W-1:0] m_fwd_slot;
    logic [SLOT_W-1:0] m_bwd_slot;
    logic [NODE_W-1:0] m_fwd_entry_node;
    logic [NODE_W-1:0] m_bwd_entry_node;
    logic [NODE_W-1:0] m_entry_weight;
    logic              m_out_of_range;

    // words still to send, and result words still owed by the block
    edge_word_t edge_words[$];
    slot_word_t owed_slots[$];

    // predictor state: degree tables that turn into cursors, running sums
    logic [SLOT_W-1:0] fwd_deg [0:NODES] = '{default: '0};
    logic [SLOT_W-1:0] bwd_deg [0:NODES] = '{default: '0};
    logic [SLOT_W-1:0] fwd_sum = '0;
    logic [SLOT_W-1:0] bwd_sum = '0;

    int         err_count = 0;
    int         n_random  = 0;
    edge_word_t tx_word   = '0;
    int         tx_gap    = 0;
    bit         tx_quiet  = 1'b0;
    int         rx_hold   = 0;
    bit         rx_quiet  = 1'b0;

    bidirectional_csr_builder_top #(
        .NODE_COUNT    (NODES),
        .EDGE_CAPACITY (CAP)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_src_node       (s_src_node),
        .s_dst_node       (s_dst_node),
        .s_edge_weight    (s_edge_weight),
        .s_scan_index     (s_scan_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_fwd_slot       (m_fwd_slot),
        .m_bwd_slot       (m_bwd_slot),
        .m_fwd_entry_node (m_fwd_entry_node),
        .m_bwd_entry_node (m_bwd_entry_node),
        .m_entry_weight   (m_entry_weight),
        .m_out_of_range   (m_out_of_range)
    );

    // 2 ns clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // saturating add at the slot limit
    function automatic logic [SLOT_W-1:0] clamp_add(
        input logic [SLOT_W-1:0] a,
        input logic [SLOT_W-1:0] b
    );
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > SAT_LIM) ? SLOT_W'(SAT_LIM) : s[SLOT_W-1:0];
    endfunction

    // updates the predictor state for one word; returns 1 if a result is due
    function automatic bit predict_slots(input edge_word_t w, output slot_word_t r);
        bit                src_ok;
        bit                dst_ok;
        logic [SLOT_W-1:0] df;
        logic [SLOT_W-1:0] db;
        r      = '0;
        src_ok = (w.src < NODES);
        dst_ok = (w.dst < NODES);
        case (w.mode)
            MODE_COUNT: begin
                // each side counts on its own, no result either way
                if (dst_ok) fwd_deg[w.dst] = clamp_add(fwd_deg[w.dst], SLOT_W'(1));
                if (src_ok) bwd_deg[w.src] = clamp_add(bwd_deg[w.src], SLOT_W'(1));
                return 1'b0;
            end
            MODE_SCAN: begin
                if (w.idx > NODES) begin
                    // beyond the last table entry: flag only, state untouched
                    r.oor = 1'b1;
                    return 1'b1;
                end
                if (w.idx == 0) begin
                    fwd_sum = '0;
                    bwd_sum = '0;
                end
                df = fwd_deg[w.idx];
                db = bwd_deg[w.idx];
                fwd_deg[w.idx] = fwd_sum;
                bwd_deg[w.idx] = bwd_sum;
                r.fwd_slot = fwd_sum;
                r.bwd_slot = bwd_sum;
                fwd_sum = clamp_add(fwd_sum, df);
                bwd_sum = clamp_add(bwd_sum, db);
                return 1'b1;
            end
            MODE_PLACE: begin
                // skipped side reports slot and node as zero
                if (dst_ok) begin
                    r.fwd_slot = fwd_deg[w.dst];
                    r.fwd_node = w.src;
                    fwd_deg[w.dst] = clamp_add(fwd_deg[w.dst], SLOT_W'(1));
                end
                if (src_ok) begin
                    r.bwd_slot = bwd_deg[w.src];
                    r.bwd_node = w.dst;
                    bwd_deg[w.src] = clamp_add(bwd_deg[w.src], SLOT_W'(1));
                end
                r.weight = w.wgt;
                r.oor    = !(src_ok && dst_ok);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic push_word(input mode_t m, input logic [NODE_W-1:0] src,
                             input logic [NODE_W-1:0] dst, input logic [NODE_W-1:0] wgt,
                             input logic [IDX_W-1:0] idx);
        edge_word_t w;
        w = '{mode: m, src: src, dst: dst, wgt: wgt, idx: idx};
        edge_words.insert(edge_words.size(), w);
        if (m != MODE_NONE) n_random++;
    endtask

    // node id: mostly from the round's pool, sometimes near or past the end
    function automatic logic [NODE_W-1:0] pick_node(input int base, input int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) return base + $urandom_range(0, span - 1);
        if (r < 92) return $urandom_range(NODES - 2, NODES + 1);
        if (r < 96) return $urandom();
        return 32'hFFFF_FFFF;
    endfunction

    // ignored words, out-of-range scans and fully random words
    task automatic push_noise(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 9);
            if (r < 3)
                push_word(MODE_NONE, $urandom(), $urandom(), $urandom(),
                          IDX_W'($urandom_range(0, 8191)));
            else if (r < 6)
                push_word(MODE_SCAN, $urandom(), $urandom(), $urandom(),
                          IDX_W'($urandom_range(NODES + 1, 8191)));
            else
                push_word(mode_t'($urandom_range(0, 3)), $urandom(), $urandom(),
                          $urandom(), IDX_W'($urandom_range(0, 8191)));
        end
    endtask

    // one well-formed pass: count the edges, scan the pool, place the edges
    task automatic push_round();
        edge_word_t round_edges[$];
        edge_word_t e;
        int         base;
        int         span;
        int         n_edges;
        int         k;
        int         i;
        span    = $urandom_range(4, 48);
        base    = ($urandom_range(0, 3) == 0) ? NODES - span : 0;
        n_edges = $urandom_range(8, 40);
        for (i = 0; i < n_edges; i++) begin
            e = '{mode: MODE_COUNT, src: pick_node(base, span), dst: pick_node(base, span),
                  wgt: $urandom(), idx: IDX_W'($urandom_range(0, 8191))};
            round_edges.insert(round_edges.size(), e);
            push_word(MODE_COUNT, e.src, e.dst, e.wgt, e.idx);
        end
        if ($urandom_range(0, 2) == 0) push_noise($urandom_range(1, 3));
        // scan always restarts at node zero; high pools jump up to their base
        push_word(MODE_SCAN, $urandom(), $urandom(), $urandom(), 0);
        for (i = (base == 0) ? 1 : base; i <= base + span; i++) begin
            k = $urandom_range(0, 39);
            if (k == 0) continue;
            push_word(MODE_SCAN, $urandom(), $urandom(), $urandom(), IDX_W'(i));
            if (k == 1) push_word(MODE_SCAN, $urandom(), $urandom(), $urandom(), IDX_W'(i));
        end
        if (base == 0 && $urandom_range(0, 3) == 0)
            push_word(MODE_SCAN, $urandom(), $urandom(), $urandom(), IDX_W'(NODES));
        if ($urandom_range(0, 2) == 0) push_noise($urandom_range(1, 3));
        // place in shuffled order
        while (round_edges.size() != 0) begin
            k = $urandom_range(0, round_edges.size() - 1);
            e = round_edges[k];
            round_edges.delete(k);
            push_word(MODE_PLACE, e.src, e.dst, $urandom(), IDX_W'($urandom_range(0, 8191)));
        end
        push_noise($urandom_range(1, 4));
    endtask

    // stimulus, end of run and final verdict
    initial begin
        // directed: field extremes, every mode, each corner of the range rules
        push_word(MODE_COUNT, 0, 0, 0, 0);
        push_word(MODE_COUNT, NODES - 1, NODES - 1, 32'hFFFF_FFFF, 13'h1FFF);
        push_word(MODE_COUNT, NODES, 1, 0, 0);                // source side skipped
        push_word(MODE_COUNT, 1, NODES, 0, 0);                // destination side skipped
        push_word(MODE_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        push_word(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF);
        push_word(MODE_SCAN, 0, 0, 0, 0);
        push_word(MODE_SCAN, 0, 0, 0, 1);
        push_word(MODE_SCAN, 0, 0, 0, 1);                     // repeated index
        push_word(MODE_SCAN, 0, 0, 0, IDX_W'(NODES - 1));
        push_word(MODE_SCAN, 0, 0, 0, IDX_W'(NODES));         // last table entry
        push_word(MODE_SCAN, 0, 0, 0, IDX_W'(NODES + 1));     // just past the end
        push_word(MODE_SCAN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF);
        push_word(MODE_SCAN, 0, 0, 0, 2);                     // out of order
        push_word(MODE_PLACE, 0, 0, 0, 0);
        push_word(MODE_PLACE, NODES - 1, NODES - 1, 32'hFFFF_FFFF, 13'h1FFF);
        push_word(MODE_PLACE, NODES, 1, 32'h5A5A_A5A5, 0);
        push_word(MODE_PLACE, 1, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 0);
        push_word(MODE_PLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, 0);
        push_word(MODE_SCAN, 0, 0, 0, 0);                     // restart of the sums
        push_word(MODE_PLACE, 0, 0, 32'h0000_0001, 0);
        push_word(MODE_NONE, 0, 0, 0, 0);

        n_random = 0;
        while (n_random < N_RANDOM) push_round();

        // reset held, then released
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // all words taken, all results back, then a short drain
        while (edge_words.size() != 0 || s_valid) @(posedge aclk);
        while (owed_slots.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0 && owed_slots.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // hard stop in case the handshakes hang
    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // driver: one word in flight, next word only after acceptance and gap
    always @(posedge aclk) begin : drive_proc
        slot_word_t due;
        edge_word_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            // accepted word: advance the predictor on what was on the bus
            if (s_valid && s_ready) begin
                if (predict_slots(tx_word, due)) owed_slots.insert(owed_slots.size(), due);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (edge_words.size() != 0) begin
                    nxt = edge_words.pop_front();
                    tx_word       <= nxt;
                    s_mode        <= nxt.mode;
                    s_src_node    <= nxt.src;
                    s_dst_node    <= nxt.dst;
                    s_edge_weight <= nxt.wgt;
                    s_scan_index  <= nxt.idx;
                    s_valid       <= 1'b1;
                    tx_gap        <= pick_gap(tx_quiet);
                    // long back-to-back stretches now and then
                    if ($urandom_range(0, 199) == 0) tx_quiet <= !tx_quiet;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, in-order compare of each result word
    always @(posedge aclk) begin : watch_proc
        slot_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_slots.size() == 0) begin
                    report_mismatch("result word with none owed", 32'(m_fwd_slot), 32'd0);
                end else begin
                    want = owed_slots.pop_front();
                    if (m_fwd_slot !== want.fwd_slot)
                        report_mismatch("fwd_slot", 32'(m_fwd_slot), 32'(want.fwd_slot));
                    if (m_bwd_slot !== want.bwd_slot)
                        report_mismatch("bwd_slot", 32'(m_bwd_slot), 32'(want.bwd_slot));
                    if (m_fwd_entry_node !== want.fwd_node)
                        report_mismatch("fwd_entry_node", m_fwd_entry_node, want.fwd_node);
                    if (m_bwd_entry_node !== want.bwd_node)
                        report_mismatch("bwd_entry_node", m_bwd_entry_node, want.bwd_node);
                    if (m_entry_weight !== want.weight)
                        report_mismatch("entry_weight", m_entry_weight, want.weight);
                    if (m_out_of_range !== want.oor)
                        report_mismatch("out_of_range", 32'(m_out_of_range), 32'(want.oor));
                end
            end
            if (rx_hold != 0) begin
                rx_hold <= rx_hold - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 7) == 0) rx_hold <= pick_gap(1'b0);
                if ($urandom_range(0, 599) == 0) rx_quiet <= !rx_quiet;
            end
        end
    end

endmodule
